// ----- src/vector3_fixed_point_alu_defines.svh -----
// Assertion macros shared by the vector ALU checker.
`ifndef VECTOR3_FIXED_POINT_ALU_DEFINES_SVH
`define VECTOR3_FIXED_POINT_ALU_DEFINES_SVH

// same-cycle implication
`define VFA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VFA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/vfa_pkg.sv -----
// Opcodes, error codes, stage types and saturation helper for the vector ALU.
package vfa_pkg;

   localparam logic [3:0] OP_ADD     = 4'd0;
   localparam logic [3:0] OP_SUB     = 4'd1;
   localparam logic [3:0] OP_MUL     = 4'd2;
   localparam logic [3:0] OP_DIV     = 4'd3;
   localparam logic [3:0] OP_SCALE   = 4'd4;
   localparam logic [3:0] OP_DOT     = 4'd5;
   localparam logic [3:0] OP_NORM    = 4'd6;
   localparam logic [3:0] OP_DIST    = 4'd7;
   localparam logic [3:0] OP_UNIT    = 4'd8;
   localparam logic [3:0] OP_UNIT_AB = 4'd9;
   localparam logic [3:0] OP_SET_LEN = 4'd10;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_DIV0     = 2'd1;
   localparam logic [1:0] ERR_ZERO_LEN = 2'd2;
   localparam logic [1:0] ERR_OVF      = 2'd3;

   localparam int SQRT_BITS = 32;

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [65:0] prod;
      logic signed [31:0] addsub;
      logic               addsub_ov;
      logic signed [32:0] num;
      logic [31:0]        den;
      logic               b_zero;
      logic               b_neg;
   } vfa_lane_type;

   typedef struct packed {
      logic [3:0]         cmd;
      logic signed [31:0] s;
      logic [2:0][31:0]   r;
      logic [31:0]        sc;
      logic               ov;
      logic               dz;
      logic               zl;
      logic               wide;
      logic [2:0][32:0]   num;
      logic [2:0][31:0]   den;
      logic [2:0]         b_zero;
      logic [2:0]         b_neg;
   } vfa_side_type;

   // {overflow, clamped value}
   function automatic logic [32:0] sat32(input logic signed [67:0] v);
      logic [32:0] res;
      if (v > 68'sd2147483647) begin
         res = {1'b1, Q_MAX};
      end else if (v < -68'sd2147483648) begin
         res = {1'b1, Q_MIN};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

endpackage

// ----- src/vector3_fixed_point_alu.sv -----
// The square root (33 stages) and divider (32 + FRAC_BITS stages) make up most of the
// pipeline. Throughput: one request per cycle; the whole pipeline holds while a result
// waits under rsp_stall.
// Reset clears the valid pipeline and rsp_valid only; no clearing pass.
module vector3_fixed_point_alu import vfa_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_cmd,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_scale_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_r_x,
   output logic signed [31:0] rsp_r_y,
   output logic signed [31:0] rsp_r_z,
   output logic signed [31:0] rsp_scalar_out,
   output logic [1:0]         rsp_error_code
);

   localparam int NUM_W    = 32 + FRAC_BITS;
   localparam int SQ_LAT   = SQRT_BITS + 1;
   localparam int PIPE_LEN = 4 + SQ_LAT + NUM_W + 1;
   localparam logic signed [65:0] HALF66 = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] HALF64 = 64'sd1 <<< (FRAC_BITS - 1);

   logic adv, accept;
   logic [PIPE_LEN-1:0] vld_in, vld_ff;

   // input stage
   logic [3:0]         cmd_ff, cmd_l1_ff, cmd_l2_ff;
   logic signed [31:0] a_ff [3];
   logic signed [31:0] b_ff [3];
   logic signed [31:0] s_ff, s_l1_ff, s_l2_ff;
   logic               wide_ff, wide_l1_ff;
   logic [2:0]         wide_lane;
   logic signed [32:0] wd [3];

   vfa_lane_type lane_q [3];

   // merge stage
   logic signed [65:0] rq [3];
   logic [32:0]        msat [3];
   logic signed [67:0] dsum;
   logic [32:0]        dsat;
   vfa_side_type       side_m_in, side_m_ff;
   logic [63:0]        rad_m_in, rad_m_ff;

   // square root and divider
   vfa_side_type       side_sq_ff [SQ_LAT];
   logic [32:0]        root;
   logic [32:0]        n_sat;
   vfa_side_type       side_b, side_dv_in;
   vfa_side_type       side_dv_ff [NUM_W];
   logic [32:0]        num_mag [3];
   logic [NUM_W-1:0]   div_num [3];
   logic [32:0]        div_den [3];
   logic [NUM_W-1:0]   quo [3];

   // post-divide stage
   vfa_side_type       side_d, side_p_ff;
   logic               neg;
   logic signed [NUM_W:0] qs [3];
   logic [32:0]        qsat [3];
   logic signed [31:0] dres_in [3];
   logic signed [31:0] dres_ff [3];
   logic [2:0]         dov_in, dov_ff;
   logic signed [63:0] sprod_in [3];
   logic signed [63:0] sprod_ff [3];

   // output stage
   logic signed [63:0] srq [3];
   logic [32:0]        ssat [3];
   logic signed [31:0] r_in [3];
   logic signed [31:0] r_ff [3];
   logic               ov_out;
   logic [1:0]         err_in, err_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] sc_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign vld_in    = {vld_ff[PIPE_LEN-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[PIPE_LEN-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wd[i]        = 33'(b_ff[i]) - 33'(a_ff[i]);
         wide_lane[i] = (wd[i][32] ^ wd[i][31]) || (wd[i] == -33'sd2147483648);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd_ff     <= req_cmd;
         a_ff[0]    <= req_a_x;
         a_ff[1]    <= req_a_y;
         a_ff[2]    <= req_a_z;
         b_ff[0]    <= req_b_x;
         b_ff[1]    <= req_b_y;
         b_ff[2]    <= req_b_z;
         s_ff       <= req_scale_value;
         cmd_l1_ff  <= cmd_ff;
         cmd_l2_ff  <= cmd_l1_ff;
         s_l1_ff    <= s_ff;
         s_l2_ff    <= s_l1_ff;
         wide_ff    <= |wide_lane;
         wide_l1_ff <= wide_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      vfa_lane u_lane (
         .clock    (clock),
         .en       (adv),
         .cmd      (cmd_ff),
         .a        (a_ff[i]),
         .b        (b_ff[i]),
         .s        (s_ff),
         .wide     (|wide_lane),
         .lane_out (lane_q[i])
      );
   end

   // merge: rounded products, dot sum, radicand
   always_comb begin
      side_m_in      = '0;
      side_m_in.cmd  = cmd_l2_ff;
      side_m_in.s    = s_l2_ff;
      side_m_in.wide = wide_l1_ff;
      rad_m_in       = '0;
      dsum           = 68'(HALF66);
      for (int i = 0; i < 3; i++) begin
         rq[i]   = (lane_q[i].prod + HALF66) >>> FRAC_BITS;
         msat[i] = sat32(68'(rq[i]));
         dsum    = dsum + 68'(lane_q[i].prod);
         rad_m_in = rad_m_in + lane_q[i].prod[63:0];
         side_m_in.num[i]    = lane_q[i].num;
         side_m_in.den[i]    = lane_q[i].den;
         side_m_in.b_zero[i] = lane_q[i].b_zero;
         side_m_in.b_neg[i]  = lane_q[i].b_neg;
      end
      dsat = sat32(dsum >>> FRAC_BITS);
      unique case (cmd_l2_ff)
         OP_ADD, OP_SUB: begin
            for (int i = 0; i < 3; i++) begin
               side_m_in.r[i] = lane_q[i].addsub;
            end
            side_m_in.ov = lane_q[0].addsub_ov | lane_q[1].addsub_ov | lane_q[2].addsub_ov;
         end
         OP_MUL, OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               side_m_in.r[i] = msat[i][31:0];
            end
            side_m_in.ov = msat[0][32] | msat[1][32] | msat[2][32];
         end
         OP_DOT: begin
            side_m_in.sc = dsat[31:0];
            side_m_in.ov = dsat[32];
         end
         default: begin
         end
      endcase
      side_m_in.dz = (cmd_l2_ff == OP_DIV) && (|side_m_in.b_zero);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_m_ff <= side_m_in;
         rad_m_ff  <= rad_m_in;
         side_sq_ff[0] <= side_m_ff;
         for (int j = 1; j < SQ_LAT; j++) begin
            side_sq_ff[j] <= side_sq_ff[j-1];
         end
      end
   end

   vfa_sqrt u_sqrt (
      .clock (clock),
      .en    (adv),
      .rad   (rad_m_ff),
      .root  (root)
   );

   // norm results and divider operands
   always_comb begin
      side_b     = side_sq_ff[SQ_LAT-1];
      side_dv_in = side_b;
      n_sat      = sat32(68'(root));
      unique case (side_b.cmd)
         OP_NORM: begin
            side_dv_in.sc = n_sat[31:0];
            side_dv_in.ov = n_sat[32];
         end
         OP_DIST: begin
            if (side_b.wide) begin
               side_dv_in.sc = Q_MAX;
               side_dv_in.ov = 1'b1;
            end else begin
               side_dv_in.sc = n_sat[31:0];
               side_dv_in.ov = n_sat[32];
            end
         end
         default: begin
         end
      endcase
      side_dv_in.zl = (side_b.cmd == OP_UNIT || side_b.cmd == OP_UNIT_AB ||
                       side_b.cmd == OP_SET_LEN) && (root == 33'd0);
      for (int i = 0; i < 3; i++) begin
         num_mag[i] = side_b.num[i][32] ? 33'(-$signed(side_b.num[i])) : side_b.num[i];
         div_num[i] = NUM_W'(num_mag[i]) << FRAC_BITS;
         div_den[i] = (side_b.cmd == OP_DIV) ? {1'b0, side_b.den[i]} : root;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      vfa_div #(.NumWidth(NUM_W)) u_div (
         .clock (clock),
         .en    (adv),
         .num   (div_num[i]),
         .den   (div_den[i]),
         .quo   (quo[i])
      );
   end

   // signed quotient, saturation, set_length product
   always_comb begin
      side_d = side_dv_ff[NUM_W-1];
      for (int i = 0; i < 3; i++) begin
         neg     = side_d.num[i][32] ^ ((side_d.cmd == OP_DIV) && side_d.b_neg[i]);
         qs[i]   = neg ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
         qsat[i] = sat32(68'(qs[i]));
         if ((side_d.cmd == OP_DIV) && side_d.b_zero[i]) begin
            if (side_d.num[i][32]) begin
               dres_in[i] = Q_MIN;
            end else if (side_d.num[i] == 33'sd0) begin
               dres_in[i] = 32'sd0;
            end else begin
               dres_in[i] = Q_MAX;
            end
            dov_in[i] = 1'b0;
         end else begin
            dres_in[i] = qsat[i][31:0];
            dov_in[i]  = qsat[i][32];
         end
         sprod_in[i] = 64'(dres_in[i]) * 64'(side_d.s);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_dv_ff[0] <= side_dv_in;
         for (int j = 1; j < NUM_W; j++) begin
            side_dv_ff[j] <= side_dv_ff[j-1];
         end
         side_p_ff <= side_d;
         for (int i = 0; i < 3; i++) begin
            dres_ff[i]  <= dres_in[i];
            sprod_ff[i] <= sprod_in[i];
         end
         dov_ff <= dov_in;
      end
   end

   // result select and error code
   always_comb begin
      ov_out = side_p_ff.ov;
      for (int i = 0; i < 3; i++) begin
         srq[i]  = (sprod_ff[i] + HALF64) >>> FRAC_BITS;
         ssat[i] = sat32(68'(srq[i]));
         unique case (side_p_ff.cmd)
            OP_ADD, OP_SUB, OP_MUL, OP_SCALE: r_in[i] = side_p_ff.r[i];
            OP_DIV: begin
               r_in[i] = dres_ff[i];
               ov_out  = ov_out | dov_ff[i];
            end
            OP_UNIT, OP_UNIT_AB: r_in[i] = side_p_ff.zl ? 32'sd0 : dres_ff[i];
            OP_SET_LEN: begin
               r_in[i] = side_p_ff.zl ? 32'sd0 : ssat[i][31:0];
               ov_out  = ov_out | (!side_p_ff.zl && ssat[i][32]);
            end
            default: r_in[i] = 32'sd0;
         endcase
      end
      priority if (side_p_ff.dz) begin
         err_in = ERR_DIV0;
      end else if (side_p_ff.zl) begin
         err_in = ERR_ZERO_LEN;
      end else if (ov_out) begin
         err_in = ERR_OVF;
      end else begin
         err_in = ERR_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            r_ff[i] <= r_in[i];
         end
         sc_ff  <= side_p_ff.sc;
         err_ff <= err_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_r_x        = r_ff[0];
   assign rsp_r_y        = r_ff[1];
   assign rsp_r_z        = r_ff[2];
   assign rsp_scalar_out = sc_ff;
   assign rsp_error_code = err_ff;

endmodule

// ----- src/vfa_lane.sv -----
// One element lane: add/sub, operand select and the element multiplier.
module vfa_lane import vfa_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [3:0]         cmd,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   input  logic signed [31:0] s,
   input  logic               wide,
   output vfa_lane_type       lane_out
);

   logic signed [32:0] a_ext, b_ext, d, nv, v_sel, as_sum;
   logic [32:0]        d_mag, d_half;
   logic [32:0]        as_sat;
   logic signed [32:0] mx_in, my_in, mx_ff, my_ff;
   logic signed [32:0] num_in, num_ff;
   logic [31:0]        den_in, den_ff;
   logic signed [31:0] addsub_ff;
   logic               addsub_ov_ff, bz_ff, bneg_ff;
   logic signed [65:0] prod_in;
   vfa_lane_type       lane_ff;

   always_comb begin
      a_ext  = 33'(a);
      b_ext  = 33'(b);
      d      = b_ext - a_ext;
      d_mag  = d[32] ? 33'(-d) : 33'(d);
      d_half = {1'b0, d_mag[32:1]};
      if (!wide) begin
         nv = d;
      end else begin
         nv = d[32] ? -$signed(d_half) : $signed(d_half);
      end
      v_sel  = (cmd == OP_NORM || cmd == OP_UNIT || cmd == OP_SET_LEN) ? a_ext : nv;
      as_sum = (cmd == OP_SUB) ? a_ext - b_ext : a_ext + b_ext;
      as_sat = sat32(68'(as_sum));
      unique case (cmd)
         OP_SCALE: begin
            mx_in = a_ext;
            my_in = 33'(s);
         end
         OP_NORM, OP_DIST, OP_UNIT, OP_UNIT_AB, OP_SET_LEN: begin
            mx_in = v_sel;
            my_in = v_sel;
         end
         default: begin
            mx_in = a_ext;
            my_in = b_ext;
         end
      endcase
      num_in  = (cmd == OP_DIV) ? a_ext : v_sel;
      den_in  = b[31] ? 32'(-b) : 32'(b);
      prod_in = mx_ff * my_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff        <= mx_in;
         my_ff        <= my_in;
         addsub_ff    <= as_sat[31:0];
         addsub_ov_ff <= as_sat[32];
         num_ff       <= num_in;
         den_ff       <= den_in;
         bz_ff        <= (b == 32'sd0);
         bneg_ff      <= b[31];
         lane_ff.prod      <= prod_in;
         lane_ff.addsub    <= addsub_ff;
         lane_ff.addsub_ov <= addsub_ov_ff;
         lane_ff.num       <= num_ff;
         lane_ff.den       <= den_ff;
         lane_ff.b_zero    <= bz_ff;
         lane_ff.b_neg     <= bneg_ff;
      end
   end

   assign lane_out = lane_ff;

endmodule

// ----- src/vfa_sqrt.sv -----
// Pipelined rounded integer square root, one root bit per stage.
module vfa_sqrt import vfa_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [32:0] root
);

   logic [63:0]          rem_ff [SQRT_BITS];
   logic [SQRT_BITS-1:0] q_ff   [SQRT_BITS];
   logic [32:0]          root_in, root_ff;

   for (genvar j = 0; j < SQRT_BITS; j++) begin : g_step
      localparam int K = SQRT_BITS - 1 - j;
      logic [63:0]          rem_prev, rem_in;
      logic [SQRT_BITS-1:0] q_prev, q_in;
      logic [65:0]          need;
      logic                 ge;
      if (j == 0) begin : g_first
         assign rem_prev = rad;
         assign q_prev   = '0;
      end else begin : g_rest
         assign rem_prev = rem_ff[j-1];
         assign q_prev   = q_ff[j-1];
      end
      always_comb begin
         need   = (66'(q_prev) << (K + 1)) + (66'(1) << (2 * K));
         ge     = 66'(rem_prev) >= need;
         rem_in = ge ? 64'(66'(rem_prev) - need) : rem_prev;
         q_in   = ge ? (q_prev | (SQRT_BITS'(1) << K)) : q_prev;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            q_ff[j]   <= q_in;
         end
      end
   end

   always_comb begin
      if (rem_ff[SQRT_BITS-1] > 64'(q_ff[SQRT_BITS-1])) begin
         root_in = 33'(q_ff[SQRT_BITS-1]) + 33'd1;
      end else begin
         root_in = 33'(q_ff[SQRT_BITS-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= root_in;
      end
   end

   assign root = root_ff;

endmodule

// ----- src/vfa_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module vfa_div #(
   parameter int NumWidth = 48
) (
   input  logic                clock,
   input  logic                en,
   input  logic [NumWidth-1:0] num,
   input  logic [32:0]         den,
   output logic [NumWidth-1:0] quo
);

   logic [32:0]         rem_ff  [NumWidth];
   logic [NumWidth-1:0] work_ff [NumWidth];
   logic [32:0]         den_ff  [NumWidth];

   for (genvar j = 0; j < NumWidth; j++) begin : g_step
      logic [32:0]         rem_prev, den_prev, rem_in;
      logic [NumWidth-1:0] work_prev, work_in;
      logic [33:0]         t;
      logic                ge;
      if (j == 0) begin : g_first
         assign rem_prev  = '0;
         assign work_prev = num;
         assign den_prev  = den;
      end else begin : g_rest
         assign rem_prev  = rem_ff[j-1];
         assign work_prev = work_ff[j-1];
         assign den_prev  = den_ff[j-1];
      end
      always_comb begin
         t       = {rem_prev, work_prev[NumWidth-1]};
         ge      = t >= {1'b0, den_prev};
         rem_in  = ge ? 33'(t - {1'b0, den_prev}) : t[32:0];
         work_in = {work_prev[NumWidth-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            work_ff[j] <= work_in;
            den_ff[j]  <= den_prev;
         end
      end
   end

   assign quo = work_ff[NumWidth-1];

endmodule

// ----- src/vfa_checker.sv -----
// Port-level checks for the vector ALU, bound to the top level.
`include "vector3_fixed_point_alu_defines.svh"

module vfa_checker import vfa_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_r_x,
   input logic signed [31:0] rsp_r_y,
   input logic signed [31:0] rsp_r_z,
   input logic signed [31:0] rsp_scalar_out,
   input logic [1:0]         rsp_error_code
);

   `VFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid,
                    "response dropped while stalled")
   `VFA_ASSERT_NOW(a_stall_src, req_stall, rsp_valid && rsp_stall,
                   "request stalled without backpressure")
   `VFA_ASSERT_NOW(a_zlen_zero, rsp_valid && rsp_error_code == ERR_ZERO_LEN,
                   rsp_r_x == 32'sd0 && rsp_r_y == 32'sd0 && rsp_r_z == 32'sd0 &&
                   rsp_scalar_out == 32'sd0, "zero-length result not cleared")
   `VFA_ASSERT_NOW(a_div0_scalar, rsp_valid && rsp_error_code == ERR_DIV0,
                   rsp_scalar_out == 32'sd0, "divide result carries a scalar")

endmodule

bind vector3_fixed_point_alu vfa_checker u_vfa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_r_x        (rsp_r_x),
   .rsp_r_y        (rsp_r_y),
   .rsp_r_z        (rsp_r_z),
   .rsp_scalar_out (rsp_scalar_out),
   .rsp_error_code (rsp_error_code)
);

// ----- dv/vector3_fixed_point_alu_tb.sv -----
// Self-checking testbench for the three-element fixed-point vector ALU.
`timescale 1ns / 100ps

module vector3_fixed_point_alu_tb;
   import vfa_pkg::*;

   localparam int FRAC = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 700;
   localparam longint LMAX = 64'sd2147483647;
   localparam longint LMIN = -64'sd2147483648;

   typedef struct {
      logic [3:0]         cmd;
      logic signed [31:0] a [3];
      logic signed [31:0] b [3];
      logic signed [31:0] s;
   } vec_request_type;

   typedef struct {
      logic signed [31:0] r [3];
      logic signed [31:0] sc;
      logic [1:0]         err;
   } vec_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [3:0]         req_cmd = '0;
   logic signed [31:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [31:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic signed [31:0] req_scale_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_r_x, rsp_r_y, rsp_r_z, rsp_scalar_out;
   logic [1:0]         rsp_error_code;

   vec_request_type pending_requests [$];
   vec_result_type  expected_results [$];
   vec_request_type on_bus;
   int              sent_count = 0;
   int              quiet_cycles = 0;
   bit              failed = 1'b0;
   wire             calm = (sent_count >= 350) && (sent_count < 470);

   vector3_fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp32(input longint v, inout bit ov);
      if (v > LMAX) begin
         ov = 1'b1;
         return LMAX[31:0];
      end
      if (v < LMIN) begin
         ov = 1'b1;
         return LMIN[31:0];
      end
      return v[31:0];
   endfunction

   function automatic longint fx_mul(input longint x, input longint y);
      return (x * y + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned rounded_norm(input longint x, input longint y,
                                                    input longint z);
      longint unsigned acc, root, bitpos;
      acc = magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y)
            + magnitude(z) * magnitude(z);
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > acc) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (acc >= root + bitpos) begin
            acc = acc - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      if (acc > root) root = root + 1;
      return root;
   endfunction

   function automatic bit unit_of(input longint v [3], output longint u [3]);
      longint unsigned n;
      n = rounded_norm(v[0], v[1], v[2]);
      for (int i = 0; i < 3; i++) u[i] = 0;
      if (n == 0) return 1'b0;
      for (int i = 0; i < 3; i++) u[i] = (v[i] * (64'sd1 <<< FRAC)) / longint'(n);
      return 1'b1;
   endfunction

   function automatic vec_result_type predict_vector_op(input vec_request_type q);
      vec_result_type res;
      longint a [3], b [3], d [3], u [3], r [3];
      longint s, sc, hi, lo, p, h, m;
      bit ov, dz, wide, zl;
      ov = 0; dz = 0; wide = 0; zl = 0; sc = 0;
      s = q.s;
      for (int i = 0; i < 3; i++) begin
         a[i] = q.a[i];
         b[i] = q.b[i];
         d[i] = b[i] - a[i];
         r[i] = 0;
         if (magnitude(d[i]) >= 64'd2147483648) wide = 1'b1;
      end
      case (q.cmd)
         OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], ov);
         OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], ov);
         OP_MUL: for (int i = 0; i < 3; i++) r[i] = clamp32(fx_mul(a[i], b[i]), ov);
         OP_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (b[i] == 0) begin
                  dz = 1'b1;
                  r[i] = (a[i] > 0) ? LMAX : ((a[i] < 0) ? LMIN : 0);
               end else begin
                  r[i] = clamp32((a[i] * (64'sd1 <<< FRAC)) / b[i], ov);
               end
            end
         end
         OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp32(fx_mul(a[i], s), ov);
         OP_DOT: begin
            hi = 0;
            lo = 0;
            for (int i = 0; i < 3; i++) begin
               p = a[i] * b[i];
               h = p >>> FRAC;
               hi += h;
               lo += p - (h <<< FRAC);
            end
            hi += (lo + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
            sc = clamp32(hi, ov);
         end
         OP_NORM: sc = clamp32(longint'(rounded_norm(a[0], a[1], a[2])), ov);
         OP_DIST: begin
            if (wide) begin
               ov = 1'b1;
               sc = LMAX;
            end else begin
               sc = clamp32(longint'(rounded_norm(d[0], d[1], d[2])), ov);
            end
         end
         OP_UNIT: zl = !unit_of(a, r);
         OP_UNIT_AB: begin
            if (wide) begin
               for (int i = 0; i < 3; i++) begin
                  m = longint'(magnitude(d[i]) >> 1);
                  d[i] = (d[i] < 0) ? -m : m;
               end
            end
            zl = !unit_of(d, r);
         end
         OP_SET_LEN: begin
            zl = !unit_of(a, u);
            if (!zl) for (int i = 0; i < 3; i++) r[i] = clamp32(fx_mul(u[i], s), ov);
         end
         default: ;
      endcase
      for (int i = 0; i < 3; i++) res.r[i] = r[i][31:0];
      res.sc = sc[31:0];
      if (dz) res.err = ERR_DIV0;
      else if (zl) res.err = ERR_ZERO_LEN;
      else if (ov) res.err = ERR_OVF;
      else res.err = ERR_OK;
      return res;
   endfunction

   task automatic queue_request(input logic [3:0] cmd,
                                input logic signed [31:0] ax, ay, az, bx, by, bz, s);
      vec_request_type q;
      q.cmd = cmd;
      q.a[0] = ax; q.a[1] = ay; q.a[2] = az;
      q.b[0] = bx; q.b[1] = by; q.b[2] = bz;
      q.s = s;
      pending_requests.push_back(q);
   endtask

   function automatic logic signed [31:0] random_operand();
      case ($urandom_range(0, 9))
         0: return 32'sd0;
         1: return Q_MAX;
         2: return Q_MIN;
         3, 4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_vector_op(on_bus));
            sent_count <= sent_count + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
               on_bus = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_cmd <= on_bus.cmd;
               req_a_x <= on_bus.a[0];
               req_a_y <= on_bus.a[1];
               req_a_z <= on_bus.a[2];
               req_b_x <= on_bus.b[0];
               req_b_y <= on_bus.b[1];
               req_b_z <= on_bus.b[2];
               req_scale_value <= on_bus.s;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      vec_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result");
               failed = 1'b1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_r_x !== want.r[0]) begin
                  $error("r_x expected %0h actual %0h", want.r[0], rsp_r_x);
                  failed = 1'b1;
               end
               if (rsp_r_y !== want.r[1]) begin
                  $error("r_y expected %0h actual %0h", want.r[1], rsp_r_y);
                  failed = 1'b1;
               end
               if (rsp_r_z !== want.r[2]) begin
                  $error("r_z expected %0h actual %0h", want.r[2], rsp_r_z);
                  failed = 1'b1;
               end
               if (rsp_scalar_out !== want.sc) begin
                  $error("scalar_out expected %0h actual %0h", want.sc, rsp_scalar_out);
                  failed = 1'b1;
               end
               if (rsp_error_code !== want.err) begin
                  $error("error_code expected %0d actual %0d", want.err, rsp_error_code);
                  failed = 1'b1;
               end
            end
         end
         rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 36);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [3:0] cmd;
      logic signed [31:0] ax, ay, az;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      queue_request(OP_ADD, Q_MAX, Q_MIN, 32'sh10000, 32'sd1, -32'sd1, 32'sh10000, 0);
      queue_request(OP_SUB, Q_MIN, Q_MAX, 32'sd5, 32'sd1, -32'sd1, 32'sd7, 0);
      queue_request(OP_MUL, Q_MAX, Q_MIN, 32'sh18000, Q_MAX, Q_MIN, -32'sh8000, 0);
      queue_request(OP_MUL, 32'sd1, -32'sd1, 32'sh8000, 32'sh8000, 32'sh8000, 32'sd1, 0);
      queue_request(OP_DIV, 32'sh30000, -32'sh30000, 0, 0, 0, 0, 0);
      queue_request(OP_DIV, Q_MAX, Q_MIN, 32'sh10000, 32'sd1, -32'sd1, -32'sh20000, 0);
      queue_request(OP_SCALE, Q_MAX, Q_MIN, 32'sh12345, 0, 0, 0, Q_MIN);
      queue_request(OP_SCALE, 32'sh10000, -32'sh10000, 32'sd3, 0, 0, 0, 32'sh8000);
      queue_request(OP_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0);
      queue_request(OP_DOT, Q_MIN, 32'sh8000, -32'sd3, Q_MIN, 32'sd1, 32'sd7, 0);
      queue_request(OP_NORM, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0);
      queue_request(OP_NORM, 32'sh30000, 32'sh40000, 0, 0, 0, 0, 0);
      queue_request(OP_DIST, Q_MIN, 0, 0, Q_MAX, 0, 0, 0);
      queue_request(OP_DIST, 32'sh10000, 32'sh20000, 32'sd5, -32'sd7, 32'sd9, 0, 0);
      queue_request(OP_UNIT, 0, 0, 0, 32'sd3, 32'sd4, 32'sd5, 0);
      queue_request(OP_UNIT, Q_MIN, Q_MAX, 32'sd1, 0, 0, 0, 0);
      queue_request(OP_UNIT_AB, 32'sd9, -32'sd9, 32'sd4, 32'sd9, -32'sd9, 32'sd4, 0);
      queue_request(OP_UNIT_AB, Q_MIN, Q_MAX, 0, Q_MAX, Q_MIN, 32'sd3, 0);
      queue_request(OP_SET_LEN, 0, 0, 0, 0, 0, 0, Q_MAX);
      queue_request(OP_SET_LEN, 32'sh10000, 32'sd1, -32'sd1, 0, 0, 0, Q_MAX);
      queue_request(OP_SET_LEN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, Q_MIN);
      queue_request(4'd11, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6, 32'sd7);
      queue_request(4'd15, Q_MAX, Q_MIN, -32'sd1, -32'sd1, Q_MIN, Q_MAX, -32'sd1);

      // sender holds off until the pipeline is empty
      wait_for_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                           : 4'($urandom_range(0, 10));
         ax = random_operand();
         ay = random_operand();
         az = random_operand();
         if ((cmd == OP_UNIT || cmd == OP_SET_LEN) && $urandom_range(0, 7) == 0) begin
            ax = 0; ay = 0; az = 0;
         end
         if (cmd == OP_UNIT_AB && $urandom_range(0, 7) == 0)
            queue_request(cmd, ax, ay, az, ax, ay, az, random_operand());
         else
            queue_request(cmd, ax, ay, az, random_operand(), random_operand(),
                          random_operand(), random_operand());
      end

      wait_for_drain();
      repeat (200) @(posedge clock);
      if (!failed) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
